// ----- src/sliding_window_median_core_assert.svh -----
// Assertion macros used by the running median filter datapath.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SWM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define SWM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SWM_ASSERT_ALWAYS(lbl, expr, msg)
`define SWM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/swm_pkg.sv -----
// Shared types and constants of the running median filter.
package swm_pkg;

    localparam int CFG_BITS = 7;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

    typedef struct packed {
        logic take;
        logic arr_rd;
        logic victim_ld;
        logic rem_rd;
        logic rem_cmp;
        logic rem_done;
        logic ins_start;
        logic ins_rd;
        logic ins_cmp;
        logic ins_zero;
        logic ins_done;
        logic med_rd0;
        logic med_rd1;
        logic out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic need_drop;
        logic j_eq_fill;
        logic j_zero;
        logic ins_gt;
        logic full_after;
    } t_dp_sts;

endpackage

// ----- src/swm_ctrl.sv -----
// Sequencer of the running median filter: request handshake and step control.
module swm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  swm_pkg::t_dp_sts i_sts,
    output swm_pkg::t_dp_cmd o_cmd
);
    import swm_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_CHECK     = 14'b00000000000010,
        S_ARR_RD    = 14'b00000000000100,
        S_VICTIM    = 14'b00000000001000,
        S_REM_RD    = 14'b00000000010000,
        S_REM_CMP   = 14'b00000000100000,
        S_REM_DONE  = 14'b00000001000000,
        S_INS_START = 14'b00000010000000,
        S_INS_RD    = 14'b00000100000000,
        S_INS_CMP   = 14'b00001000000000,
        S_INS_DONE  = 14'b00010000000000,
        S_MED_RD0   = 14'b00100000000000,
        S_MED_RD1   = 14'b01000000000000,
        S_MED_SUM   = 14'b10000000000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    t_dp_cmd n_cmd;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.need_drop ? S_ARR_RD : S_INS_START;
            end
            S_ARR_RD: begin
                n_cmd.arr_rd = 1'b1;
                n_state      = S_VICTIM;
            end
            S_VICTIM: begin
                n_cmd.victim_ld = 1'b1;
                n_state         = S_REM_RD;
            end
            S_REM_RD: begin
                if (i_sts.j_eq_fill) begin
                    n_state = S_REM_DONE;
                end else begin
                    n_cmd.rem_rd = 1'b1;
                    n_state      = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                n_cmd.rem_cmp = 1'b1;
                n_state       = S_REM_RD;
            end
            S_REM_DONE: begin
                n_cmd.rem_done = 1'b1;
                n_state        = S_CHECK;
            end
            S_INS_START: begin
                n_cmd.ins_start = 1'b1;
                n_state         = S_INS_RD;
            end
            S_INS_RD: begin
                if (i_sts.j_zero) begin
                    n_cmd.ins_zero = 1'b1;
                    n_state        = S_INS_DONE;
                end else begin
                    n_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                n_cmd.ins_cmp = 1'b1;
                n_state       = i_sts.ins_gt ? S_INS_RD : S_INS_DONE;
            end
            S_INS_DONE: begin
                n_cmd.ins_done = 1'b1;
                n_state        = i_sts.full_after ? S_MED_RD0 : S_IDLE;
            end
            S_MED_RD0: begin
                n_cmd.med_rd0 = 1'b1;
                n_state       = S_MED_RD1;
            end
            S_MED_RD1: begin
                n_cmd.med_rd1 = 1'b1;
                n_state       = S_MED_SUM;
            end
            S_MED_SUM: begin
                if (out_free) begin
                    n_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (n_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- src/swm_dp.sv -----
// Datapath of the running median filter: arrival ring, sorted window, counters.
`include "sliding_window_median_core_assert.svh"

module swm_dp #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [swm_pkg::CFG_BITS-1:0]        i_cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_restart,
    input  swm_pkg::t_dp_cmd                    i_cmd,
    output swm_pkg::t_dp_sts                    o_sts,
    output logic signed [SAMPLE_BITS:0]         o_median_x2
);
    import swm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = CW + 1;
    localparam int WW = (CW > CFG_BITS) ? CW : CFG_BITS;

    logic signed [SAMPLE_BITS-1:0] arr_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] srt_mem [MAX_WINDOW];

    logic [CFG_BITS-1:0]           r_window_size;
    logic [CW-1:0]                 r_fill;
    logic [AW-1:0]                 r_oldest;
    logic [CW-1:0]                 r_j;
    logic                          r_found;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_victim;
    logic signed [SAMPLE_BITS-1:0] r_acc;
    logic signed [SAMPLE_BITS:0]   r_median;
    logic signed [SAMPLE_BITS-1:0] r_arr_rd;
    logic signed [SAMPLE_BITS-1:0] r_srt_rd;

    logic [WW-1:0]                 cfg_ext;
    logic [CW-1:0]                 win;
    logic [CW-1:0]                 med_hi;
    logic [CW-1:0]                 med_lo;
    logic [PW-1:0]                 pos_sum;
    logic [PW-1:0]                 pos_wrap;
    logic [AW-1:0]                 ring_wr_addr;
    logic [AW-1:0]                 oldest_inc;
    logic [CW-1:0]                 j_dec;
    logic                          ins_gt;

    logic                          srt_we;
    logic [AW-1:0]                 srt_waddr;
    logic signed [SAMPLE_BITS-1:0] srt_wdata;
    logic                          srt_re;
    logic [AW-1:0]                 srt_raddr;

    // clamp window to 1..MAX_WINDOW
    always_comb begin
        cfg_ext = WW'(r_window_size);
        if (cfg_ext == '0) begin
            win = CW'(1);
        end else if (cfg_ext > WW'(MAX_WINDOW)) begin
            win = CW'(MAX_WINDOW);
        end else begin
            win = CW'(cfg_ext);
        end
    end

    assign med_hi = win >> 1;
    assign med_lo = win[0] ? med_hi : med_hi - CW'(1);

    assign pos_sum      = PW'(r_oldest) + PW'(r_fill);
    assign pos_wrap     = (pos_sum >= PW'(MAX_WINDOW)) ? pos_sum - PW'(MAX_WINDOW) : pos_sum;
    assign ring_wr_addr = pos_wrap[AW-1:0];
    assign oldest_inc   = (r_oldest == AW'(MAX_WINDOW - 1)) ? '0 : r_oldest + AW'(1);
    assign j_dec        = r_j - CW'(1);
    assign ins_gt       = (r_srt_rd > r_sample);

    assign o_sts.need_drop  = (r_fill >= win);
    assign o_sts.j_eq_fill  = (r_j == r_fill);
    assign o_sts.j_zero     = (r_j == '0);
    assign o_sts.ins_gt     = ins_gt;
    assign o_sts.full_after = ((PW'(r_fill) + PW'(1)) == PW'(win));

    assign o_median_x2 = r_median;

    always_comb begin
        srt_we    = 1'b0;
        srt_waddr = r_j[AW-1:0];
        srt_wdata = r_sample;
        if (i_cmd.rem_cmp && r_found) begin
            srt_we    = 1'b1;
            srt_waddr = j_dec[AW-1:0];
            srt_wdata = r_srt_rd;
        end else if (i_cmd.ins_zero) begin
            srt_we    = 1'b1;
            srt_waddr = '0;
        end else if (i_cmd.ins_cmp) begin
            srt_we    = 1'b1;
            srt_wdata = ins_gt ? r_srt_rd : r_sample;
        end
    end

    always_comb begin
        srt_re    = 1'b1;
        srt_raddr = r_j[AW-1:0];
        if (i_cmd.ins_rd) begin
            srt_raddr = j_dec[AW-1:0];
        end else if (i_cmd.med_rd0) begin
            srt_raddr = med_lo[AW-1:0];
        end else if (i_cmd.med_rd1) begin
            srt_raddr = med_hi[AW-1:0];
        end else if (!i_cmd.rem_rd) begin
            srt_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_start) begin
            arr_mem[ring_wr_addr] <= r_sample;
        end
        if (i_cmd.arr_rd) begin
            r_arr_rd <= arr_mem[r_oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (srt_we) begin
            srt_mem[srt_waddr] <= srt_wdata;
        end
        if (srt_re) begin
            r_srt_rd <= srt_mem[srt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_RESET;
            r_fill        <= '0;
            r_oldest      <= '0;
            r_j           <= '0;
            r_found       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_size <= i_cfg_wr_data;
            end
            if (i_cmd.take && i_restart) begin
                r_fill   <= '0;
                r_oldest <= '0;
            end else if (i_cmd.rem_done) begin
                r_fill   <= r_fill - CW'(1);
                r_oldest <= oldest_inc;
            end else if (i_cmd.ins_done) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.victim_ld) begin
                r_j     <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.rem_cmp) begin
                r_j <= r_j + CW'(1);
                if (!r_found && (r_srt_rd == r_victim)) begin
                    r_found <= 1'b1;
                end
            end else if (i_cmd.ins_start) begin
                r_j <= r_fill;
            end else if (i_cmd.ins_cmp && ins_gt) begin
                r_j <= j_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.victim_ld) begin
            r_victim <= r_arr_rd;
        end
        if (i_cmd.med_rd1) begin
            r_acc <= r_srt_rd;
        end
        if (i_cmd.out_ld) begin
            r_median <= (SAMPLE_BITS + 1)'(r_acc) + (SAMPLE_BITS + 1)'(r_srt_rd);
        end
    end

    `SWM_ASSERT_ALWAYS(a_fill_bound, r_fill <= CW'(MAX_WINDOW), "fill count above window depth")
    `SWM_ASSERT_IMPL(a_no_drop_empty, i_cmd.rem_done, r_fill != '0, "drop from an empty window")
    `SWM_ASSERT_NEXT(a_fill_inc, i_cmd.ins_done, r_fill == $past(r_fill) + CW'(1), "fill not advanced on insert")

endmodule

// ----- src/sliding_window_median_core.sv -----
// Running median filter. Each request is first taken in; then, while the window is full,
// the oldest sample is found in the sorted window and removed, then the new sample is inserted
// in order, and a median is produced once the window is full, held while a previous result
// is stalled. No new request is taken until the current one is finished.
// The scans walk the sorted window memory, one entry per read-then-write pair.
// Synchronous active-low reset empties the window, clears the output valid and sets window size 3.
module sliding_window_median_core #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [swm_pkg::CFG_BITS-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SAMPLE_BITS:0]  o_median_x2
);
    import swm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    swm_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (i_sample),
        .i_restart     (i_restart),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_median_x2   (o_median_x2)
    );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the running median filter core.
`timescale 1ns / 100ps

module tb_top;

    localparam int SB        = 16;
    localparam int MAX_WIN   = 64;
    localparam int IDLE_WAIT = 5000;
    localparam int LIMIT     = 2000000;

    typedef struct {
        bit                     do_cfg;
        logic [swm_pkg::CFG_BITS-1:0] cfg;
        logic signed [SB-1:0]   sample;
        logic                   restart;
        bit                     known;
        logic signed [SB:0]     median;
    } t_dir_row;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [swm_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic signed [SB-1:0]         sample      = '0;
    logic                         restart     = 1'b0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic signed [SB:0]           median_x2;

    logic signed [SB:0]           median_q [$];
    t_dir_row                     dir_rows [$];
    int                           phase_win [$] = '{5, 64, 2, 127, 1, 8, 0, 33, 3, 65, 16, 7, 4, 6};
    int                           mismatches = 0;
    int                           cycles     = 0;
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;

    logic [swm_pkg::CFG_BITS-1:0] win_reg = swm_pkg::WINDOW_RESET;
    logic signed [SB-1:0]         ring        [MAX_WIN];
    logic signed [SB-1:0]         sorted_vals [MAX_WIN];
    int                           fill   = 0;
    int                           oldest = 0;

    sliding_window_median_core #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SB)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_sample      (sample),
        .i_restart     (restart),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_median_x2   (median_x2)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t: %s", $realtime, what);
    endtask

    task automatic next_median(input logic signed [SB-1:0] s, input logic clear,
                               output bit produced, output logic signed [SB:0] med);
        int w;
        int i;
        int pos;
        logic signed [SB-1:0] victim;
        logic signed [SB:0]   lo;
        logic signed [SB:0]   hi;
        w = int'(win_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIN) w = MAX_WIN;
        if (clear) begin
            fill   = 0;
            oldest = 0;
        end
        while (fill >= w) begin
            victim = ring[oldest];
            i = 0;
            while (i < fill && sorted_vals[i] != victim) i++;
            while (i + 1 < fill) begin
                sorted_vals[i] = sorted_vals[i + 1];
                i++;
            end
            fill--;
            oldest = (oldest + 1) % MAX_WIN;
        end
        ring[(oldest + fill) % MAX_WIN] = s;
        pos = fill;
        while (pos > 0 && sorted_vals[pos - 1] > s) begin
            sorted_vals[pos] = sorted_vals[pos - 1];
            pos--;
        end
        sorted_vals[pos] = s;
        fill++;
        produced = (fill == w);
        med = '0;
        if (produced) begin
            hi = (SB + 1)'(sorted_vals[w / 2]);
            lo = (w % 2 == 1) ? hi : (SB + 1)'(sorted_vals[w / 2 - 1]);
            med = lo + hi;
        end
    endtask

    task automatic add_row(input bit do_cfg, input int cfg, input int s, input bit r,
                           input bit known, input int med);
        t_dir_row row;
        row.do_cfg  = do_cfg;
        row.cfg     = cfg[swm_pkg::CFG_BITS-1:0];
        row.sample  = s[SB-1:0];
        row.restart = r;
        row.known   = known;
        row.median  = med[SB:0];
        dir_rows = {dir_rows, row};
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 23;
                recv_idle_pct = 59;
            end
            1: begin
                send_idle_pct = 59;
                recv_idle_pct = 23;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_request(input logic signed [SB-1:0] s, input logic r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        sample   <= s;
        restart  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_BITS-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        win_reg      = v;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("median_x2 %0d with no request pending", median_x2));
            end else begin
                if (median_x2 !== median_q[0]) begin
                    report_mismatch($sformatf("median_x2 got %0d want %0d",
                                              median_x2, median_q[0]));
                end
                void'(median_q.pop_front());
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("sliding_window_median_core: mismatch");
        $finish;
    end

    initial begin
        bit                   produced;
        logic signed [SB:0]   med;
        logic signed [SB-1:0] s;
        logic                 r;
        int                   n;

        add_row(0, 0,      0,      0, 0, 0);
        add_row(0, 0,      0,      0, 0, 0);
        add_row(0, 0,      0,      0, 1, 0);
        add_row(0, 0,      32767,  0, 1, 0);
        add_row(0, 0,      32767,  0, 1, 65534);
        add_row(0, 0,      32767,  0, 1, 65534);
        add_row(0, 0,      -32768, 0, 1, 65534);
        add_row(0, 0,      -32768, 0, 1, -65536);
        add_row(0, 0,      -32768, 0, 1, -65536);
        add_row(0, 0,      5,      1, 0, 0);
        add_row(0, 0,      7,      0, 0, 0);
        add_row(0, 0,      6,      0, 1, 12);
        add_row(0, 0,      6,      0, 0, 0);
        add_row(0, 0,      -1,     0, 0, 0);
        add_row(0, 0,      -1,     1, 0, 0);
        add_row(1, 1,      100,    0, 1, 200);
        add_row(1, 0,      -32768, 0, 1, -65536);
        add_row(1, 2,      3,      0, 0, 0);
        add_row(0, 0,      4,      0, 0, 0);
        add_row(1, 127,    1,      0, 0, 0);
        add_row(1, 4,      9,      0, 0, 0);
        add_row(1, 3,      0,      0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(0);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].do_cfg) begin
                settle();
                write_window(dir_rows[k].cfg);
            end
            next_median(dir_rows[k].sample, dir_rows[k].restart, produced, med);
            if (dir_rows[k].known) begin
                median_q = {median_q, dir_rows[k].median};
            end else if (produced) begin
                median_q = {median_q, med};
            end
            send_request(dir_rows[k].sample, dir_rows[k].restart);
        end

        foreach (phase_win[p]) begin
            settle();
            write_window(phase_win[p][swm_pkg::CFG_BITS-1:0]);
            set_idle(p * 3 / phase_win.size());
            n = (phase_win[p] >= 33) ? 90 : 30;
            repeat (n) begin
                case ($urandom_range(3))
                    0: s = SB'($urandom);
                    1: s = SB'(int'($urandom_range(8)) - 4);
                    2: begin
                        case ($urandom_range(5))
                            0: s = 16'sh8000;
                            1: s = 16'sh7fff;
                            2: s = 16'sh8001;
                            3: s = 16'sh7ffe;
                            4: s = 16'sh0000;
                            default: s = 16'shffff;
                        endcase
                    end
                    default: s = SB'(int'($urandom_range(2000)) - 1000);
                endcase
                r = ($urandom_range(59) == 0);
                next_median(s, r, produced, med);
                if (produced) begin
                    median_q = {median_q, med};
                end
                send_request(s, r);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("sliding_window_median_core: match");
        end else begin
            $display("sliding_window_median_core: mismatch");
        end
        $finish;
    end

endmodule
